@@ src/hps_pkg.sv @@
`timescale 1ns / 1ps

package hps_pkg;

  localparam logic [6:0] DUTY_MAX = 7'd100;

  // reset values of the configuration registers
  localparam logic [15:0] RST_GAIN_P     = 16'd1280;
  localparam logic [15:0] RST_GAIN_I     = 16'd0;
  localparam logic [15:0] RST_GAIN_D     = 16'd0;
  localparam logic [6:0]  RST_STEPS      = 7'd43;
  localparam logic [14:0] RST_OFFSET     = 15'd10000;
  localparam logic [6:0]  RST_DEAD_BAND  = 7'd10;
  localparam logic [6:0]  RST_START_DUTY = 7'd50;
  localparam logic [6:0]  RST_RAMP_STEP  = 7'd2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int PROD_W   = 32;
  localparam int PROD_I_W = 48;
  localparam int ACC_W    = 49;

  // smallest |acc| whose magnitude saturates to the duty ceiling
  localparam int SAT_LIMIT = (int'(DUTY_MAX) + 1) * 256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_STEPS      = 3'd3,
    REG_OFFSET     = 3'd4,
    REG_DEAD_BAND  = 3'd5,
    REG_START_DUTY = 3'd6,
    REG_RAMP_STEP  = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ACT_HOLD,
    ACT_SEEK,
    ACT_HOME,
    ACT_DRIVE,
    ACT_BRAKE
  } act_t;

  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [6:0]  steps;
    logic [14:0] offset;
    logic [6:0]  dead_band;
    logic [6:0]  start_duty;
    logic [6:0]  ramp_step;
  } cfg_t;

  // tracking stage to multiplier stage
  typedef struct packed {
    act_t        act;
    logic [6:0]  seek_duty;
    logic        load;
    logic        homed;
    logic [15:0] perr;
    logic [15:0] err;
    logic [15:0] diff;
    logic [31:0] sum;
  } hps_a_t;

  // multiplier stage to output stage
  typedef struct packed {
    act_t                act;
    logic [6:0]          seek_duty;
    logic                load;
    logic                homed;
    logic [15:0]         perr;
    logic [PROD_W-1:0]   prod_p;
    logic [PROD_I_W-1:0] prod_i;
    logic [PROD_W-1:0]   prod_d;
  } hps_b_t;

  function automatic logic [6:0] clamp_duty(input logic [7:0] v);
    logic [6:0] r;
    if (v > {1'b0, DUTY_MAX}) begin
      r = DUTY_MAX;
    end else begin
      r = v[6:0];
    end
    return r;
  endfunction

endpackage

@@ src/hps_track.sv @@
`timescale 1ns / 1ps

module hps_track (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load_a,
  input  logic [15:0]   position,
  input  logic          limit_switch,
  input  logic          ramp_tick,
  input  logic          command_valid,
  input  logic [7:0]    command,
  input  hps_pkg::cfg_t cfg,
  input  logic          start_wr,
  input  logic [6:0]    start_val,
  output hps_pkg::hps_a_t a_q
);

  logic        homed_r, homed_nxt;
  logic [6:0]  ramp_duty_r, ramp_duty_nxt;
  logic [7:0]  target_byte_r, target_byte_nxt;
  logic        pending_r, pending_nxt;
  logic [15:0] prev_err_r, prev_err_nxt;
  logic [31:0] err_sum_r, err_sum_nxt;
  hps_pkg::hps_a_t a_r, a_nxt;

  logic [7:0]  tbyte_eff;
  logic        pend_eff;
  logic [14:0] scaled;
  logic [15:0] target;
  logic [15:0] err;
  logic [15:0] diff;
  logic [31:0] sum_new;
  logic signed [16:0] err_s, band_s;
  logic        drive, brake;
  logic [7:0]  ramp_sum;
  hps_pkg::act_t act;
  logic        load;

  assign tbyte_eff = command_valid ? command : target_byte_r;
  assign pend_eff  = command_valid | pending_r;
  assign scaled    = {7'b0, tbyte_eff} * {8'b0, cfg.steps};
  assign target    = {1'b0, scaled} + {1'b0, cfg.offset};
  assign err       = target - position;
  assign diff      = err - prev_err_r;
  assign sum_new   = err_sum_r + {{16{err[15]}}, err};
  assign err_s     = $signed({err[15], err});
  assign band_s    = $signed({10'b0, cfg.dead_band});
  assign drive     = (err_s > band_s) || (err_s < -band_s);
  assign brake     = (err_s < band_s) && (err_s > -band_s);
  assign ramp_sum  = {1'b0, ramp_duty_r} + {1'b0, cfg.ramp_step};

  always_comb begin
    homed_nxt       = homed_r;
    ramp_duty_nxt   = ramp_duty_r;
    target_byte_nxt = target_byte_r;
    pending_nxt     = pending_r;
    prev_err_nxt    = prev_err_r;
    err_sum_nxt     = err_sum_r;
    act             = hps_pkg::ACT_HOLD;
    load            = 1'b0;
    if (!homed_r) begin
      if (limit_switch) begin
        act = hps_pkg::ACT_SEEK;
        if (ramp_tick && (ramp_duty_r < hps_pkg::DUTY_MAX)) begin
          ramp_duty_nxt = hps_pkg::clamp_duty(ramp_sum);
        end
      end else begin
        // switch closed: coast, reload encoder, done homing
        act           = hps_pkg::ACT_HOME;
        homed_nxt     = 1'b1;
        load          = 1'b1;
        ramp_duty_nxt = 7'd0;
      end
    end else begin
      target_byte_nxt = tbyte_eff;
      pending_nxt     = pend_eff;
      if (pend_eff && (target != position)) begin
        err_sum_nxt  = sum_new;
        prev_err_nxt = err;
        if (drive) begin
          act = hps_pkg::ACT_DRIVE;
        end else if (brake) begin
          act         = hps_pkg::ACT_BRAKE;
          pending_nxt = 1'b0;
        end
      end
    end
  end

  always_comb begin
    a_nxt.act       = act;
    a_nxt.seek_duty = hps_pkg::clamp_duty({1'b0, ramp_duty_r});
    a_nxt.load      = load;
    a_nxt.homed     = homed_nxt;
    a_nxt.perr      = prev_err_nxt;
    a_nxt.err       = err;
    a_nxt.diff      = diff;
    a_nxt.sum       = sum_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      homed_r       <= 1'b0;
      ramp_duty_r   <= hps_pkg::RST_START_DUTY;
      target_byte_r <= 8'd0;
      pending_r     <= 1'b0;
      prev_err_r    <= 16'd0;
      err_sum_r     <= 32'd0;
    end else begin
      if (load_a) begin
        homed_r       <= homed_nxt;
        target_byte_r <= target_byte_nxt;
        pending_r     <= pending_nxt;
        prev_err_r    <= prev_err_nxt;
        err_sum_r     <= err_sum_nxt;
      end
      if (start_wr && !homed_r) begin
        ramp_duty_r <= hps_pkg::clamp_duty({1'b0, start_val});
      end else if (load_a) begin
        ramp_duty_r <= ramp_duty_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_a) begin
      a_r <= a_nxt;
    end
  end

  assign a_q = a_r;

endmodule

@@ src/hps_mult.sv @@
`timescale 1ns / 1ps

module hps_mult (
  input  logic            clk,
  input  logic            load_b,
  input  hps_pkg::hps_a_t a_q,
  input  logic [15:0]     gain_p,
  input  logic [15:0]     gain_i,
  input  logic [15:0]     gain_d,
  output hps_pkg::hps_b_t b_q
);

  logic signed [hps_pkg::PROD_W-1:0]   p_prod;
  logic signed [hps_pkg::PROD_I_W-1:0] i_prod;
  logic signed [hps_pkg::PROD_W-1:0]   d_prod;
  hps_pkg::hps_b_t b_r, b_nxt;

  assign p_prod = $signed(gain_p) * $signed(a_q.err);
  assign i_prod = $signed(gain_i) * $signed(a_q.sum);
  assign d_prod = $signed(gain_d) * $signed(a_q.diff);

  always_comb begin
    b_nxt.act       = a_q.act;
    b_nxt.seek_duty = a_q.seek_duty;
    b_nxt.load      = a_q.load;
    b_nxt.homed     = a_q.homed;
    b_nxt.perr      = a_q.perr;
    b_nxt.prod_p    = p_prod;
    b_nxt.prod_i    = i_prod;
    b_nxt.prod_d    = d_prod;
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      b_r <= b_nxt;
    end
  end

  assign b_q = b_r;

endmodule

@@ src/hps_resolve.sv @@
`timescale 1ns / 1ps

module hps_resolve (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load_out,
  input  hps_pkg::hps_b_t b_q,
  output logic [6:0]      duty,
  output logic            drive_a,
  output logic            drive_b,
  output logic            load_position,
  output logic            is_homed,
  output logic [15:0]     position_error
);

  localparam int AccW = hps_pkg::ACC_W;
  localparam int PW   = hps_pkg::PROD_W;
  localparam int IW   = hps_pkg::PROD_I_W;
  localparam logic signed [AccW-1:0] SatPos = AccW'(hps_pkg::SAT_LIMIT);
  localparam logic signed [AccW-1:0] SatNeg = -SatPos;

  logic signed [AccW-1:0] acc;
  logic        neg, fwd, sat;
  logic [15:0] neg_lo;
  logic [6:0]  mag;

  logic [6:0]  duty_r, duty_nxt;
  logic        bridge_a_r, bridge_a_nxt;
  logic        bridge_b_r, bridge_b_nxt;
  logic        load_r;
  logic        homed_r;
  logic [15:0] perr_r;

  assign acc = $signed({{(AccW-PW){b_q.prod_p[PW-1]}}, b_q.prod_p})
             + $signed({{(AccW-IW){b_q.prod_i[IW-1]}}, b_q.prod_i})
             + $signed({{(AccW-PW){b_q.prod_d[PW-1]}}, b_q.prod_d});

  assign neg    = acc[AccW-1];
  assign fwd    = !neg && (acc != '0);
  assign sat    = neg ? (acc <= SatNeg) : (acc >= SatPos);
  // below saturation |acc| fits in 15 bits
  assign neg_lo = 16'd0 - acc[15:0];
  assign mag    = sat ? hps_pkg::DUTY_MAX : (neg ? neg_lo[14:8] : acc[14:8]);

  always_comb begin
    duty_nxt     = duty_r;
    bridge_a_nxt = bridge_a_r;
    bridge_b_nxt = bridge_b_r;
    case (b_q.act)
      hps_pkg::ACT_SEEK: begin
        duty_nxt = b_q.seek_duty;
      end
      hps_pkg::ACT_HOME: begin
        bridge_a_nxt = 1'b0;
        bridge_b_nxt = 1'b0;
      end
      hps_pkg::ACT_DRIVE: begin
        bridge_a_nxt = fwd;
        bridge_b_nxt = !fwd;
        duty_nxt     = mag;
      end
      hps_pkg::ACT_BRAKE: begin
        bridge_a_nxt = 1'b1;
        bridge_b_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r     <= 7'd0;
      bridge_a_r <= 1'b0;
      bridge_b_r <= 1'b1;
    end else if (load_out) begin
      duty_r     <= duty_nxt;
      bridge_a_r <= bridge_a_nxt;
      bridge_b_r <= bridge_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      load_r  <= b_q.load;
      homed_r <= b_q.homed;
      perr_r  <= b_q.perr;
    end
  end

  assign duty           = duty_r;
  assign drive_a        = bridge_a_r;
  assign drive_b        = bridge_b_r;
  assign load_position  = load_r;
  assign is_homed       = homed_r;
  assign position_error = perr_r;

endmodule

@@ src/homing_pid_position_servo.sv @@
`timescale 1ns / 1ps

// channel   ports                                   direction
// ------    --------------------------------------  ---------
// in        in_valid, in_stall, in_position,        in (stall out)
//           in_limit_switch, in_ramp_tick,
//           in_command_valid, in_command
// out       out_valid, out_stall, out_duty,         out (stall in)
//           out_drive_a, out_drive_b,
//           out_load_position, out_is_homed,
//           out_position_error
// cfg       cfg_we, cfg_index, cfg_wdata            in
//
// four register stages: input, error tracking, gain multipliers, output.
// one item per cycle sustained while out_stall is low.
// rst_n is synchronous; clears the pipeline and servo state, presets the registers.
// in_stall rises only when every stage holds an item and the output is stalled.

module homing_pid_position_servo (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [15:0]                    in_position,
  input  logic                           in_limit_switch,
  input  logic                           in_ramp_tick,
  input  logic                           in_command_valid,
  input  logic [7:0]                     in_command,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [6:0]                     out_duty,
  output logic                           out_drive_a,
  output logic                           out_drive_b,
  output logic                           out_load_position,
  output logic                           out_is_homed,
  output logic signed [15:0]             out_position_error,
  input  logic                           cfg_we,
  input  logic [hps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hps_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  hps_pkg::cfg_t cfg_r;

  logic        in_v_r, a_v_r, b_v_r, out_v_r;
  logic [15:0] pos_r;
  logic        lim_r, tick_r, cmd_v_r;
  logic [7:0]  cmd_r;

  logic in_acc, load_a, load_b, load_out;
  logic free_in, free_a, free_b;
  logic start_wr;

  hps_pkg::hps_a_t a_q;
  hps_pkg::hps_b_t b_q;
  logic [15:0]     perr;

  // ready chain from the output back to the input
  assign load_out = b_v_r && (!out_v_r || !out_stall);
  assign free_b   = !b_v_r || load_out;
  assign load_b   = a_v_r && free_b;
  assign free_a   = !a_v_r || load_b;
  assign load_a   = in_v_r && free_a;
  assign free_in  = !in_v_r || load_a;
  assign in_stall = !free_in;
  assign in_acc   = in_valid && free_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        in_v_r <= 1'b1;
      end else if (load_a) begin
        in_v_r <= 1'b0;
      end
      if (load_a) begin
        a_v_r <= 1'b1;
      end else if (load_b) begin
        a_v_r <= 1'b0;
      end
      if (load_b) begin
        b_v_r <= 1'b1;
      end else if (load_out) begin
        b_v_r <= 1'b0;
      end
      if (load_out) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pos_r   <= in_position;
      lim_r   <= in_limit_switch;
      tick_r  <= in_ramp_tick;
      cmd_v_r <= in_command_valid;
      cmd_r   <= in_command;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p     <= hps_pkg::RST_GAIN_P;
      cfg_r.gain_i     <= hps_pkg::RST_GAIN_I;
      cfg_r.gain_d     <= hps_pkg::RST_GAIN_D;
      cfg_r.steps      <= hps_pkg::RST_STEPS;
      cfg_r.offset     <= hps_pkg::RST_OFFSET;
      cfg_r.dead_band  <= hps_pkg::RST_DEAD_BAND;
      cfg_r.start_duty <= hps_pkg::RST_START_DUTY;
      cfg_r.ramp_step  <= hps_pkg::RST_RAMP_STEP;
    end else if (cfg_we) begin
      case (cfg_index)
        hps_pkg::REG_GAIN_P:     cfg_r.gain_p     <= cfg_wdata;
        hps_pkg::REG_GAIN_I:     cfg_r.gain_i     <= cfg_wdata;
        hps_pkg::REG_GAIN_D:     cfg_r.gain_d     <= cfg_wdata;
        hps_pkg::REG_STEPS:      cfg_r.steps      <= cfg_wdata[6:0];
        hps_pkg::REG_OFFSET:     cfg_r.offset     <= cfg_wdata[14:0];
        hps_pkg::REG_DEAD_BAND:  cfg_r.dead_band  <= cfg_wdata[6:0];
        hps_pkg::REG_START_DUTY: cfg_r.start_duty <= cfg_wdata[6:0];
        hps_pkg::REG_RAMP_STEP:  cfg_r.ramp_step  <= cfg_wdata[6:0];
        default: begin
        end
      endcase
    end
  end

  // start duty write also reloads the homing ramp while not yet homed
  assign start_wr = cfg_we && (cfg_index == hps_pkg::REG_START_DUTY);

  hps_track u_track (
    .clk           (clk),
    .rst_n         (rst_n),
    .load_a        (load_a),
    .position      (pos_r),
    .limit_switch  (lim_r),
    .ramp_tick     (tick_r),
    .command_valid (cmd_v_r),
    .command       (cmd_r),
    .cfg           (cfg_r),
    .start_wr      (start_wr),
    .start_val     (cfg_wdata[6:0]),
    .a_q           (a_q)
  );

  hps_mult u_mult (
    .clk    (clk),
    .load_b (load_b),
    .a_q    (a_q),
    .gain_p (cfg_r.gain_p),
    .gain_i (cfg_r.gain_i),
    .gain_d (cfg_r.gain_d),
    .b_q    (b_q)
  );

  hps_resolve u_resolve (
    .clk            (clk),
    .rst_n          (rst_n),
    .load_out       (load_out),
    .b_q            (b_q),
    .duty           (out_duty),
    .drive_a        (out_drive_a),
    .drive_b        (out_drive_b),
    .load_position  (out_load_position),
    .is_homed       (out_is_homed),
    .position_error (perr)
  );

  assign out_position_error = $signed(perr);
  assign out_valid          = out_v_r;

endmodule
